>>> design/kalman_tilt_angle_fusion_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the tilt angle Kalman filter
// Implication checks sampled on clk, held off during reset.
// ---------------------------------------------------------------------------
`ifndef KALMAN_TILT_ANGLE_FUSION_ASSERT_SVH
`define KALMAN_TILT_ANGLE_FUSION_ASSERT_SVH

// antecedent |-> consequent, same cycle
`define KTAF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// antecedent |=> consequent, next cycle
`define KTAF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> design/ktaf_pkg.sv
// ---------------------------------------------------------------------------
// ktaf_pkg
// Constants and types shared by the tilt angle Kalman filter.
// ---------------------------------------------------------------------------
package ktaf_pkg;

	localparam int FRAC_COV = 24;
	localparam logic signed [31:0] Q_ONE = 32'sd16777216;

	localparam logic [31:0] RST_Q_ANGLE = 32'd16777;
	localparam logic [31:0] RST_Q_BIAS  = 32'd83886;
	localparam logic [31:0] RST_R_MEAS  = 32'd8388608;
	localparam logic [31:0] RST_PERIOD  = 32'd1678;

	localparam logic [1:0] REG_Q_ANGLE = 2'd0;
	localparam logic [1:0] REG_Q_BIAS  = 2'd1;
	localparam logic [1:0] REG_R_MEAS  = 2'd2;
	localparam logic [1:0] REG_PERIOD  = 2'd3;

	// divider request/response
	typedef struct packed {
		logic               start;
		logic signed [31:0] num;
		logic signed [33:0] den;
	} div_req_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic signed [31:0] quot;
	} div_rsp_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
		if (x > 66'sd2147483647) return 32'sh7fffffff;
		if (x < -66'sd2147483648) return 32'sh80000000;
		return x[31:0];
	endfunction

endpackage

>>> design/ktaf_if.sv
// ---------------------------------------------------------------------------
// ktaf_if
// Valid/ready channel carrying one data word of width W.
// ---------------------------------------------------------------------------
interface ktaf_if #(parameter int W = 32);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> design/ktaf_div.sv
// ---------------------------------------------------------------------------
// ktaf_div
// Restoring divider: sat32(num * 2^24 / den), truncated toward zero, den > 0.
// ---------------------------------------------------------------------------
module ktaf_div (
	input  logic                clk,
	input  logic                arst_n,
	input  ktaf_pkg::div_req_t  req,
	output ktaf_pkg::div_rsp_t  rsp
);
	localparam int NBITS = 57;

	logic [5:0]  cnt_q;
	logic        busy_q, done_q, neg_q;
	logic [56:0] dvd_q;   // |num| << 24, shifted out msb first
	logic [56:0] quo_q;
	logic [33:0] rem_q;
	logic [33:0] den_q;
	logic [34:0] trial;
	logic signed [58:0] sq;

	assign trial = {rem_q, dvd_q[56]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(NBITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.num[31];
			dvd_q <= {(req.num[31] ? -33'(req.num) : 33'(req.num)), 24'd0};
			den_q <= req.den[33:0];
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[55:0], 1'b0};
			if (!trial[34]) begin
				rem_q <= trial[33:0];
				quo_q <= {quo_q[55:0], 1'b1};
			end else begin
				rem_q <= {rem_q[32:0], dvd_q[56]};
				quo_q <= {quo_q[55:0], 1'b0};
			end
		end
	end

	assign sq = neg_q ? -59'(quo_q) : 59'(quo_q);
	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = ktaf_pkg::sat32(66'(sq));
endmodule

>>> design/kalman_tilt_angle_fusion.sv
// ---------------------------------------------------------------------------
// kalman_tilt_angle_fusion
// Two-state Kalman filter (angle, gyro bias) on one shared 32x33 multiplier.
// ---------------------------------------------------------------------------
// A request is accepted in S_IDLE, then 4 predict multiplies, two divides for
// 57 quotient bits each and the correction multiplies lead to out.valid; both
// divides are skipped when the innovation variance is not positive.
// The divider produces one quotient bit per cycle. in.ready is low while a
// request is in work.
// Reset (arst_n low) restores registers to defaults and the filter state to
// angle = bias = 0, P = identity.
// ---------------------------------------------------------------------------
`include "kalman_tilt_angle_fusion_assert.svh"

module kalman_tilt_angle_fusion #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	ktaf_if.sink        in,
	ktaf_if.source      out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	// in.data = {gyro_meas, angle_meas}; out.data = {rate_estimate, angle_estimate}
	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_MUL  = 7'b0000010,   // issue/consume one product per cycle
		S_DIV0 = 7'b0000100,
		S_DIV1 = 7'b0001000,
		S_COR  = 7'b0010000,
		S_OUT  = 7'b0100000,
		S_WAIT = 7'b1000000
	} state_t;

	state_t state_q;
	logic [3:0] step_q;

	// configuration
	logic [31:0] qa_cfg_q, qb_cfg_q, r_cfg_q, dt_cfg_q;
	logic wr;
	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qa_cfg_q <= ktaf_pkg::RST_Q_ANGLE;
			qb_cfg_q <= ktaf_pkg::RST_Q_BIAS;
			r_cfg_q  <= ktaf_pkg::RST_R_MEAS;
			dt_cfg_q <= ktaf_pkg::RST_PERIOD;
		end else if (wr && paddr[1:0] == 2'b00) begin
			case (paddr[3:2])
				ktaf_pkg::REG_Q_ANGLE: qa_cfg_q <= pwdata;
				ktaf_pkg::REG_Q_BIAS:  qb_cfg_q <= pwdata;
				ktaf_pkg::REG_R_MEAS:  r_cfg_q  <= pwdata;
				ktaf_pkg::REG_PERIOD:  dt_cfg_q <= pwdata;
				default: ;
			endcase
		end
	end
	always_comb begin
		case (paddr[3:2])
			ktaf_pkg::REG_Q_ANGLE: prdata = qa_cfg_q;
			ktaf_pkg::REG_Q_BIAS:  prdata = qb_cfg_q;
			ktaf_pkg::REG_R_MEAS:  prdata = r_cfg_q;
			ktaf_pkg::REG_PERIOD:  prdata = dt_cfg_q;
			default:               prdata = '0;
		endcase
	end

	// filter state
	logic signed [31:0] ang_q, bias_q, aa_q, ab_q, ba_q, bb_q;
	logic signed [31:0] meas_q, gyro_q, err_q, k0_q, k1_q, t0_q, t1_q;
	logic signed [31:0] rate_q;

	// sample conversion
	logic signed [SAMPLE_WIDTH-1:0] am, gm;
	assign am = in.data[SAMPLE_WIDTH-1:0];
	assign gm = in.data[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
	function automatic logic signed [31:0] to_q16(input logic signed [SAMPLE_WIDTH-1:0] s);
		return ktaf_pkg::sat32(66'(s) <<< 16);
	endfunction

	logic signed [31:0] qa_s, qb_s;
	assign qa_s = qa_cfg_q[31] ? 32'sh7fffffff : $signed(qa_cfg_q);
	assign qb_s = qb_cfg_q[31] ? 32'sh7fffffff : $signed(qb_cfg_q);

	// shared multiplier: rounded (a*b) >> 24
	logic signed [31:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [64:0] prod;
	logic signed [65:0] mq;
	assign prod = mul_a * mul_b;
	assign mq = (66'(prod) + 66'sd8388608) >>> ktaf_pkg::FRAC_COV;

	logic signed [32:0] dt33;
	assign dt33 = $signed({1'b0, dt_cfg_q});

	// operand select per step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (step_q)
			4'd0: begin mul_a = ktaf_pkg::sat32(66'(gyro_q) - 66'(bias_q)); mul_b = dt33; end
			4'd1: begin mul_a = ktaf_pkg::sat32(66'(qa_s) - 66'(ab_q) - 66'(ba_q)); mul_b = dt33; end
			4'd2: begin mul_a = bb_q; mul_b = dt33; end
			4'd3: begin mul_a = qb_s; mul_b = dt33; end
			4'd4: begin mul_a = k0_q; mul_b = 33'(t0_q); end
			4'd5: begin mul_a = k0_q; mul_b = 33'(t1_q); end
			4'd6: begin mul_a = k1_q; mul_b = 33'(t0_q); end
			4'd7: begin mul_a = k1_q; mul_b = 33'(t1_q); end
			4'd8: begin mul_a = k0_q; mul_b = 33'(err_q); end
			4'd9: begin mul_a = k1_q; mul_b = 33'(err_q); end
			default: ;
		endcase
	end

	// divider
	ktaf_pkg::div_req_t dreq;
	ktaf_pkg::div_rsp_t drsp;
	logic signed [33:0] e_val;
	logic dstart;
	assign e_val = 34'($signed({1'b0, r_cfg_q})) + 34'(aa_q);
	assign dreq.start = dstart;
	assign dreq.num = (state_q == S_DIV1) ? ba_q : aa_q;
	assign dreq.den = e_val;
	ktaf_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	logic div_issued_q;
	assign dstart = (state_q == S_DIV0 || state_q == S_DIV1) && !div_issued_q;

	logic signed [31:0] ang_pred;
	assign ang_pred = ktaf_pkg::sat32(66'(ang_q) + mq);

	// rate uses the saturated new bias
	logic signed [31:0] bias_new;
	assign bias_new = ktaf_pkg::sat32(66'(bias_q) + mq);

	assign in.ready = (state_q == S_IDLE);
	assign out.valid = (state_q == S_OUT);
	assign out.data = {rate_q, ang_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q <= '0;
			div_issued_q <= 1'b0;
			ang_q <= '0; bias_q <= '0;
			aa_q <= ktaf_pkg::Q_ONE; ab_q <= '0; ba_q <= '0; bb_q <= ktaf_pkg::Q_ONE;
		end else begin
			case (state_q)
				S_IDLE: if (in.valid) begin
					meas_q <= to_q16(am);
					gyro_q <= to_q16(gm);
					step_q <= 4'd0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					step_q <= step_q + 4'd1;
					case (step_q)
						4'd0: begin
							ang_q <= ang_pred;
							err_q <= ktaf_pkg::sat32(66'(meas_q) - 66'(ang_pred));
						end
						4'd1: aa_q <= ktaf_pkg::sat32(66'(aa_q) + mq);
						4'd2: begin
							ab_q <= ktaf_pkg::sat32(66'(ab_q) - mq);
							ba_q <= ktaf_pkg::sat32(66'(ba_q) - mq);
						end
						default: begin
							bb_q <= ktaf_pkg::sat32(66'(bb_q) + mq);
							k0_q <= '0; k1_q <= '0;
							state_q <= (e_val > 34'sd0) ? S_DIV0 : S_COR;
						end
					endcase
				end
				S_DIV0: begin
					if (drsp.done) begin
						k0_q <= drsp.quot;
						div_issued_q <= 1'b0;
						state_q <= S_DIV1;
					end else begin
						div_issued_q <= 1'b1;
					end
				end
				S_DIV1: begin
					if (drsp.done) begin
						k1_q <= drsp.quot;
						div_issued_q <= 1'b0;
						state_q <= S_COR;
					end else begin
						div_issued_q <= 1'b1;
					end
				end
				S_COR: begin
					t0_q <= aa_q; t1_q <= ab_q;
					step_q <= 4'd4;
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					step_q <= step_q + 4'd1;
					case (step_q)
						4'd4: aa_q <= ktaf_pkg::sat32(66'(aa_q) - mq);
						4'd5: ab_q <= ktaf_pkg::sat32(66'(ab_q) - mq);
						4'd6: ba_q <= ktaf_pkg::sat32(66'(ba_q) - mq);
						4'd7: bb_q <= ktaf_pkg::sat32(66'(bb_q) - mq);
						4'd8: ang_q <= ktaf_pkg::sat32(66'(ang_q) + mq);
						default: begin
							bias_q <= bias_new;
							rate_q <= ktaf_pkg::sat32(66'(gyro_q) - 66'(bias_new));
							state_q <= S_OUT;
						end
					endcase
				end
				S_OUT: if (out.ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`KTAF_ASSERT_IMP(a_ready_idle, clk, arst_n, in.ready, !out.valid)
	`KTAF_ASSERT_IMP(a_div_in_div, clk, arst_n, drsp.done, state_q == S_DIV0 || state_q == S_DIV1)
	`KTAF_ASSERT_NEXT(a_out_hold, clk, arst_n, out.valid && !out.ready, out.valid && $stable(out.data))
	`KTAF_ASSERT_IMP(a_onehot, clk, arst_n, 1'b1, $onehot(state_q))
endmodule

>>> tb/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the tilt angle Kalman filter. A queue-fed driver
// offers sample requests with random gaps, a monitor takes results under
// random backpressure and compares them with an in-bench fixed point model
// of the angle/bias filter. The noise and period registers are reprogrammed
// between phases, extremes included.
// ---------------------------------------------------------------------------
module tb;

	typedef struct packed {
		logic signed [15:0] gyro_meas;
		logic signed [15:0] angle_meas;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] rate_estimate;
		logic signed [31:0] angle_estimate;
	} estimate_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	ktaf_if #(.W(32)) sample_ch ();
	ktaf_if #(.W(64)) estimate_ch ();

	kalman_tilt_angle_fusion #(.SAMPLE_WIDTH(16)) dut (
		.clk(clk), .arst_n(arst_n), .in(sample_ch.sink), .out(estimate_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// bench copy of the filter registers and state
	logic [31:0] q_angle_cfg, q_bias_cfg, r_meas_cfg, period_cfg;
	logic signed [31:0] angle_st, bias_st, p_aa, p_ab, p_ba, p_bb;

	sample_t   pending_samples[$];
	estimate_t expected_estimates[$];
	int errors = 0;
	int samples_sent = 0;
	int estimates_seen = 0;
	int gain_bypass_count = 0;
	bit quiet_sender = 0;   // stretches with no idling on the request side
	bit quiet_receiver = 0;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	function automatic logic signed [31:0] clip32(input longint x);
		if (x > 64'sd2147483647) return 32'sh7fffffff;
		if (x < -64'sd2147483648) return 32'sh80000000;
		return x[31:0];
	endfunction

	// Q8.24 product, round to nearest with ties up (floor after bias)
	function automatic longint fx_mul(input logic signed [31:0] a, input longint b);
		longint p;
		p = longint'(a) * b + 64'sd8388608;
		return p >>> 24;
	endfunction

	task automatic filter_step(input sample_t s);
		longint dt, e;
		logic signed [31:0] meas, gyro, qa, qb, d, err, pd0, t0, t1, k0, k1;
		estimate_t r;
		dt = longint'(period_cfg);
		meas = clip32(longint'(s.angle_meas) * 65536);
		gyro = clip32(longint'(s.gyro_meas) * 65536);
		qa = clip32(longint'(q_angle_cfg));
		qb = clip32(longint'(q_bias_cfg));
		k0 = 0;
		k1 = 0;
		// predict, covariance terms from the old P
		d = clip32(longint'(gyro) - bias_st);
		angle_st = clip32(longint'(angle_st) + fx_mul(d, dt));
		err = clip32(longint'(meas) - angle_st);
		pd0 = clip32(longint'(qa) - p_ab - p_ba);
		p_aa = clip32(longint'(p_aa) + fx_mul(pd0, dt));
		p_ab = clip32(longint'(p_ab) - fx_mul(p_bb, dt));
		p_ba = clip32(longint'(p_ba) - fx_mul(p_bb, dt));
		p_bb = clip32(longint'(p_bb) + fx_mul(qb, dt));
		// gains; a non-positive innovation variance leaves both gains zero
		e = longint'(r_meas_cfg) + p_aa;
		if (e > 0) begin
			k0 = clip32((longint'(p_aa) * 64'sd16777216) / e);
			k1 = clip32((longint'(p_ba) * 64'sd16777216) / e);
		end else begin
			gain_bypass_count++;
		end
		t0 = p_aa;
		t1 = p_ab;
		p_aa = clip32(longint'(p_aa) - fx_mul(k0, t0));
		p_ab = clip32(longint'(p_ab) - fx_mul(k0, t1));
		p_ba = clip32(longint'(p_ba) - fx_mul(k1, t0));
		p_bb = clip32(longint'(p_bb) - fx_mul(k1, t1));
		angle_st = clip32(longint'(angle_st) + fx_mul(k0, err));
		bias_st = clip32(longint'(bias_st) + fx_mul(k1, err));
		r.angle_estimate = angle_st;
		r.rate_estimate = clip32(longint'(gyro) - bias_st);
		expected_estimates.push_back(r);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		errors++;
		$display("mismatch %s on result %0d: got %h want %h", what, estimates_seen,
			got, want);
	endtask

	function automatic int pick_gap(input bit quiet);
		if (quiet) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(20, 200);
		if ($urandom_range(0, 2) == 0) return $urandom_range(1, 4);
		return 0;
	endfunction

	// request driver: one request per handshake, random gaps between them
	int send_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_ch.valid <= 1'b0;
			sample_ch.data <= '0;
			send_gap <= 0;
		end else if (!sample_ch.valid || sample_ch.ready) begin
			if (sample_ch.valid) begin
				filter_step(sample_t'(sample_ch.data));
				samples_sent++;
			end
			if (send_gap != 0) begin
				send_gap <= send_gap - 1;
				sample_ch.valid <= 1'b0;
			end else if (pending_samples.size() != 0) begin
				sample_ch.data <= pending_samples.pop_front();
				sample_ch.valid <= 1'b1;
				send_gap <= pick_gap(quiet_sender);
			end else begin
				sample_ch.valid <= 1'b0;
			end
		end
	end

	// result monitor with random stalls and one long hold-off to back up the block
	int hold_cycles;
	bit long_hold_done;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			estimate_ch.ready <= 1'b0;
			hold_cycles <= 0;
			long_hold_done <= 1'b0;
		end else begin
			if (estimate_ch.valid && estimate_ch.ready) begin
				estimate_t got, want;
				got = estimate_t'(estimate_ch.data);
				if (expected_estimates.size() == 0) begin
					report_mismatch("unexpected result", got.angle_estimate, 32'd0);
				end else begin
					want = expected_estimates.pop_front();
					if (got.angle_estimate !== want.angle_estimate)
						report_mismatch("angle_estimate", got.angle_estimate,
							want.angle_estimate);
					if (got.rate_estimate !== want.rate_estimate)
						report_mismatch("rate_estimate", got.rate_estimate,
							want.rate_estimate);
				end
				estimates_seen++;
			end
			if (hold_cycles != 0) begin
				hold_cycles <= hold_cycles - 1;
				estimate_ch.ready <= 1'b0;
			end else if (!long_hold_done && estimates_seen >= 400) begin
				// block fills, input stalls while the sender keeps offering
				long_hold_done <= 1'b1;
				hold_cycles <= 1500;
				estimate_ch.ready <= 1'b0;
			end else begin
				hold_cycles <= pick_gap(quiet_receiver);
				estimate_ch.ready <= 1'b1;
			end
		end
	end

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			ktaf_pkg::REG_Q_ANGLE: q_angle_cfg = value;
			ktaf_pkg::REG_Q_BIAS:  q_bias_cfg = value;
			ktaf_pkg::REG_R_MEAS:  r_meas_cfg = value;
			ktaf_pkg::REG_PERIOD:  period_cfg = value;
			default: ;
		endcase
	endtask

	task automatic program_filter(input logic [31:0] qa, input logic [31:0] qb,
			input logic [31:0] r, input logic [31:0] dt);
		reg_write(ktaf_pkg::REG_Q_ANGLE, qa);
		reg_write(ktaf_pkg::REG_Q_BIAS, qb);
		reg_write(ktaf_pkg::REG_R_MEAS, r);
		reg_write(ktaf_pkg::REG_PERIOD, dt);
	endtask

	// wait for the block to drain; results always follow requests
	task automatic drain();
		while (pending_samples.size() != 0 || sample_ch.valid
				|| expected_estimates.size() != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic queue_sample(input int a, input int g);
		sample_t s;
		s.angle_meas = 16'(a);
		s.gyro_meas = 16'(g);
		pending_samples.push_back(s);
	endtask

	task automatic queue_random(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 3) == 0)
				queue_sample($urandom_range(0, 64) - 32, $urandom_range(0, 64) - 32);
			else
				queue_sample($urandom, $urandom);
		end
	endtask

	task automatic random_phase(input int n);
		logic [31:0] dt;
		dt = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 20);
		program_filter($urandom, $urandom, $urandom_range(1, 32'hffff_ffff), dt);
		quiet_sender = $urandom_range(0, 2) == 0;
		quiet_receiver = $urandom_range(0, 2) == 0;
		queue_random(n);
		drain();
	endtask

	initial begin
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		q_angle_cfg = ktaf_pkg::RST_Q_ANGLE;
		q_bias_cfg = ktaf_pkg::RST_Q_BIAS;
		r_meas_cfg = ktaf_pkg::RST_R_MEAS;
		period_cfg = ktaf_pkg::RST_PERIOD;
		angle_st = 0;
		bias_st = 0;
		p_aa = ktaf_pkg::Q_ONE;
		p_ab = 0;
		p_ba = 0;
		p_bb = ktaf_pkg::Q_ONE;
		arst_n = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;

		// directed: sample extremes at reset settings
		queue_sample(0, 0);
		queue_sample(32767, 32767);
		queue_sample(-32768, -32768);
		queue_sample(32767, -32768);
		queue_sample(-32768, 32767);
		queue_sample(1, -1);
		queue_sample(-1, 1);
		drain();

		// noise settings above the signed maximum, longest period
		program_filter(32'hffff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff);
		queue_sample(32767, -32768);
		queue_sample(-32768, 32767);
		queue_sample(0, 32767);
		queue_sample(-32768, -32768);
		drain();

		// smallest settings; tiny R with a growing negative covariance
		// is the easiest route to a non-positive innovation variance
		program_filter(32'd0, 32'd0, 32'd1, 32'd0);
		queue_sample(32767, 32767);
		queue_sample(-32768, 0);
		drain();
		program_filter(32'd0, 32'hffff_ffff, 32'd1, 32'hffff_ffff);
		for (int i = 0; i < 8; i++) queue_sample(-32768 + i, 32767 - i);
		drain();

		// back to defaults, then random settings phases
		program_filter(ktaf_pkg::RST_Q_ANGLE, ktaf_pkg::RST_Q_BIAS,
			ktaf_pkg::RST_R_MEAS, ktaf_pkg::RST_PERIOD);
		quiet_sender = 0;
		quiet_receiver = 0;
		queue_random(500);
		drain();
		for (int ph = 0; ph < 5; ph++) random_phase(200);

		$display("covered %0d requests over several register settings", samples_sent);
		$display("%0d results checked, %0d steps with the gain update skipped",
			estimates_seen, gain_bypass_count);
		if (errors == 0)
			$display("[kalman_tilt_angle_fusion] OK");
		else
			$display("[kalman_tilt_angle_fusion] ERROR");
		$finish;
	end

	initial begin
		#(12 * 5000000);
		$display("timeout after %0d results", estimates_seen);
		$display("[kalman_tilt_angle_fusion] ERROR");
		$finish;
	end

endmodule

>>> files.f
+incdir+design
design/ktaf_pkg.sv
design/ktaf_if.sv
design/ktaf_div.sv
design/kalman_tilt_angle_fusion.sv
tb/tb.sv
